[sv/pktrx_pkg.sv]
// Shared types, constants and the CRC-32 byte update for the packet receiver.
package pktrx_pkg;

    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [7:0]  TYPE_DATA  = 8'h1E;
    localparam logic [7:0]  TYPE_CMD   = 8'h1D;
    localparam logic [7:0]  CMD_DONE   = 8'h45;
    localparam logic [23:0] TOTAL_MAX  = 24'hFF_FFFF;
    localparam logic [9:0]  MAX_PAYLOAD_RESET = 10'd512;
    localparam logic [2:0]  HDR_LAST_INDEX    = 3'd7;

    // Output queue: two slots must be free before a byte is taken.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        VERDICT_ACK         = 3'd0,
        VERDICT_NACK_READ   = 3'd1,
        VERDICT_NACK_SEQ    = 3'd2,
        VERDICT_NACK_TYPE   = 3'd3,
        VERDICT_DONE        = 3'd4,
        VERDICT_IGNORED     = 3'd5
    } verdict_t;

    typedef enum logic {
        KIND_DATA    = 1'b0,
        KIND_VERDICT = 1'b1
    } result_kind_t;

    typedef struct packed {
        result_kind_t  result_kind;
        logic [7:0]    data_byte;
        verdict_t      verdict;
        logic [7:0]    reply_seq;
        logic [7:0]    packet_type;
        logic [15:0]   payload_len;
        logic [23:0]   accepted_total;
        logic          last;
    } result_t;

    // Results produced by one byte, in order.
    typedef struct packed {
        logic [1:0] push_n;
        result_t    res0;
        result_t    res1;
    } push_t;

    // Reflected CRC-32 update over one byte.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

[sv/pktrx_core.sv]
// Header parser, payload CRC check and verdict logic for the packet receiver.
module pktrx_core
    import pktrx_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD_LIMIT = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,
    input  logic        in_accept,
    input  logic [7:0]  rx_byte,
    output push_t       push
);

    localparam logic [15:0] PARAM_LIMIT = 16'(MAX_PAYLOAD_LIMIT);

    logic [9:0]  len_limit_reg;
    logic        in_payload_reg, in_payload_next;
    logic [2:0]  header_index_reg, header_index_next;
    logic [7:0]  hdr_type_reg, hdr_type_next;
    logic [7:0]  hdr_seq_reg, hdr_seq_next;
    logic [15:0] hdr_length_reg, hdr_length_next;
    logic [31:0] hdr_crc_reg, hdr_crc_next;
    logic [31:0] running_crc_reg, running_crc_next;
    logic [15:0] payload_count_reg, payload_count_next;
    logic [7:0]  first_byte_reg, first_byte_next;
    logic [7:0]  expected_seq_reg, expected_seq_next;
    logic [23:0] byte_total_reg, byte_total_next;

    logic [15:0] eff_limit;
    logic [31:0] crc_upd;
    logic [15:0] count_inc;
    logic [7:0]  first_byte_sel;
    logic [24:0] total_sum;

    // Verdict for an intact packet, from the current header registers.
    verdict_t    dec_verdict;
    logic [7:0]  dec_seq;
    logic [7:0]  dec_expected;
    logic [23:0] dec_total;

    result_t     res_base;

    assign eff_limit = ({6'd0, len_limit_reg} < PARAM_LIMIT) ?
                       {6'd0, len_limit_reg} : PARAM_LIMIT;
    assign crc_upd   = crc32_byte(running_crc_reg, rx_byte);
    assign count_inc = payload_count_reg + 16'd1;
    assign first_byte_sel = (in_payload_reg && payload_count_reg == 16'd0) ?
                            rx_byte : first_byte_reg;
    assign total_sum = {1'b0, byte_total_reg} + {9'd0, hdr_length_reg};

    always_comb
    begin
        dec_verdict  = VERDICT_NACK_TYPE;
        dec_seq      = hdr_seq_reg;
        dec_expected = expected_seq_reg;
        dec_total    = byte_total_reg;
        priority if (hdr_type_reg == TYPE_DATA)
        begin
            if (hdr_seq_reg != expected_seq_reg)
            begin
                dec_verdict = VERDICT_NACK_SEQ;
            end
            else
            begin
                dec_verdict  = VERDICT_ACK;
                dec_seq      = expected_seq_reg;
                dec_expected = expected_seq_reg + 8'd1;
                dec_total    = total_sum[24] ? TOTAL_MAX : total_sum[23:0];
            end
        end
        else if (hdr_type_reg == TYPE_CMD)
        begin
            if (hdr_length_reg == 16'd1 && first_byte_sel == CMD_DONE)
            begin
                dec_verdict  = VERDICT_DONE;
                dec_expected = 8'd0;
                dec_total    = 24'd0;
            end
            else
            begin
                dec_verdict = VERDICT_IGNORED;
            end
        end
        else
        begin
            dec_verdict = VERDICT_NACK_TYPE;
        end
    end

    always_comb
    begin
        in_payload_next    = in_payload_reg;
        header_index_next  = header_index_reg;
        hdr_type_next      = hdr_type_reg;
        hdr_seq_next       = hdr_seq_reg;
        hdr_length_next    = hdr_length_reg;
        hdr_crc_next       = hdr_crc_reg;
        running_crc_next   = running_crc_reg;
        payload_count_next = payload_count_reg;
        first_byte_next    = first_byte_reg;
        expected_seq_next  = expected_seq_reg;
        byte_total_next    = byte_total_reg;

        res_base.result_kind    = KIND_VERDICT;
        res_base.data_byte      = 8'd0;
        res_base.verdict        = VERDICT_ACK;
        res_base.reply_seq      = hdr_seq_reg;
        res_base.packet_type    = hdr_type_reg;
        res_base.payload_len    = hdr_length_reg;
        res_base.accepted_total = byte_total_reg;
        res_base.last           = 1'b1;

        push.push_n = 2'd0;
        push.res0   = res_base;
        push.res1   = res_base;

        if (in_accept)
        begin
            if (!in_payload_reg)
            begin
                unique case (header_index_reg)
                    3'd0:    hdr_type_next = rx_byte;
                    3'd1:    hdr_seq_next = rx_byte;
                    3'd2:    hdr_length_next = {hdr_length_reg[15:8], rx_byte};
                    3'd3:    hdr_length_next = {rx_byte, hdr_length_reg[7:0]};
                    default: hdr_crc_next = {rx_byte, hdr_crc_reg[31:8]};
                endcase
                if (header_index_reg != HDR_LAST_INDEX)
                begin
                    header_index_next = header_index_reg + 3'd1;
                end
                else
                begin
                    header_index_next = 3'd0;
                    priority if (hdr_length_reg > eff_limit)
                    begin
                        push.push_n         = 2'd1;
                        push.res0.verdict   = VERDICT_NACK_READ;
                        push.res0.reply_seq = expected_seq_reg;
                    end
                    else if (hdr_length_reg == 16'd0)
                    begin
                        push.push_n              = 2'd1;
                        push.res0.verdict        = dec_verdict;
                        push.res0.reply_seq      = dec_seq;
                        push.res0.accepted_total = dec_total;
                        expected_seq_next        = dec_expected;
                        byte_total_next          = dec_total;
                    end
                    else
                    begin
                        in_payload_next    = 1'b1;
                        running_crc_next   = CRC_INIT;
                        payload_count_next = 16'd0;
                    end
                end
            end
            else
            begin
                first_byte_next  = first_byte_sel;
                running_crc_next = crc_upd;
                push.res0.result_kind = KIND_DATA;
                push.res0.data_byte   = rx_byte;
                push.res0.verdict     = VERDICT_ACK;
                push.res0.reply_seq   = hdr_seq_reg;
                if (count_inc < hdr_length_reg)
                begin
                    push.push_n        = 2'd1;
                    payload_count_next = count_inc;
                end
                else
                begin
                    // Last payload byte: the byte itself, then the verdict.
                    push.push_n        = 2'd2;
                    push.res0.last     = 1'b0;
                    in_payload_next    = 1'b0;
                    payload_count_next = 16'd0;
                    if (~crc_upd != hdr_crc_reg)
                    begin
                        push.res1.verdict   = VERDICT_NACK_READ;
                        push.res1.reply_seq = expected_seq_reg;
                    end
                    else
                    begin
                        push.res1.verdict        = dec_verdict;
                        push.res1.reply_seq      = dec_seq;
                        push.res1.accepted_total = dec_total;
                        expected_seq_next        = dec_expected;
                        byte_total_next          = dec_total;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_limit_reg     <= MAX_PAYLOAD_RESET;
            in_payload_reg    <= 1'b0;
            header_index_reg  <= 3'd0;
            hdr_type_reg      <= 8'd0;
            hdr_seq_reg       <= 8'd0;
            hdr_length_reg    <= 16'd0;
            hdr_crc_reg       <= 32'd0;
            running_crc_reg   <= CRC_INIT;
            payload_count_reg <= 16'd0;
            first_byte_reg    <= 8'd0;
            expected_seq_reg  <= 8'd0;
            byte_total_reg    <= 24'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_limit_reg <= cfg_wdata;
            end
            in_payload_reg    <= in_payload_next;
            header_index_reg  <= header_index_next;
            hdr_type_reg      <= hdr_type_next;
            hdr_seq_reg       <= hdr_seq_next;
            hdr_length_reg    <= hdr_length_next;
            hdr_crc_reg       <= hdr_crc_next;
            running_crc_reg   <= running_crc_next;
            payload_count_reg <= payload_count_next;
            first_byte_reg    <= first_byte_next;
            expected_seq_reg  <= expected_seq_next;
            byte_total_reg    <= byte_total_next;
        end
    end

endmodule

[sv/pktrx_outq.sv]
// Small result queue: takes up to two results a cycle, hands out one.
module pktrx_outq
    import pktrx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  push_t             push,
    input  logic              pop,
    output result_t           head,
    output logic [QCNT_W-1:0] count
);

    result_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   head_reg, head_next;
    logic [QPTR_W-1:0]   tail_reg, tail_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [QPTR_W-1:0]   tail_plus1;

    assign tail_plus1 = tail_reg + QPTR_W'(1);
    assign head       = entry_reg[head_reg];
    assign count      = count_reg;

    always_comb
    begin
        head_next  = head_reg + QPTR_W'(pop);
        tail_next  = tail_reg + QPTR_W'(push.push_n);
        count_next = count_reg + QCNT_W'(push.push_n) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.push_n != 2'd0)
        begin
            entry_reg[tail_reg] <= push.res0;
        end
        if (push.push_n == 2'd2)
        begin
            entry_reg[tail_plus1] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

[sv/packet_receiver_crc_seq_check_unit.sv]
// Top level of the framed packet receiver with CRC-32 and sequence check.
// The block takes one received byte per cycle: an 8-byte header (type, sequence,
// little-endian length, little-endian CRC-32), then the payload. Each payload
// byte is passed through as a data result; a packet ends in one verdict result
// (ACK, NACK read error, NACK bad sequence, NACK invalid type, done, ignored).
// A byte is parsed and its CRC updated as it is taken: its results are written
// into a four-entry output queue at the edge that takes the byte and are offered
// from the next cycle on, one result per cycle while the sink is ready. A byte
// is taken whenever at least two queue entries are free, so a steady stream runs
// at one byte per cycle. The last payload byte of a packet yields two results,
// but the eight header bytes that follow yield at most one and let the queue
// drain, so the input stalls only while the output side holds off.
module packet_receiver_crc_seq_check_unit
    import pktrx_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD_LIMIT = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,      // payload length limit
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // data_byte[7:0], verdict[10:8], reply_seq[18:11], packet_type[26:19],
    // payload_len[42:27], accepted_total[66:43], zero fill[71:67]
    output logic [71:0] m_axis_tdata,
    output logic        m_axis_tuser,   // result_kind
    output logic        m_axis_tlast    // last
);

    logic              in_accept;
    logic              out_pop;
    push_t             push;
    result_t           head;
    logic [QCNT_W-1:0] q_count;

    assign s_axis_tready = (q_count <= QCNT_W'(QUEUE_DEPTH - 2));
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (q_count != '0);
    assign out_pop       = m_axis_tvalid && m_axis_tready;

    pktrx_core #(
        .MAX_PAYLOAD_LIMIT (MAX_PAYLOAD_LIMIT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .rx_byte   (s_axis_tdata),
        .push      (push)
    );

    pktrx_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (out_pop),
        .head  (head),
        .count (q_count)
    );

    assign m_axis_tdata = {5'd0, head.accepted_total, head.payload_len, head.packet_type,
                           head.reply_seq, head.verdict, head.data_byte};
    assign m_axis_tuser = head.result_kind;
    assign m_axis_tlast = head.last;

    // A byte that yields two results marks only the second one as last.
    assert property (@(posedge clk) disable iff (!rst_n)
        push.push_n == 2'd2 |-> !push.res0.last && push.res1.last)
        else $error("two-result push with wrong last marks");

    // Verdict results never carry a data byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
        else $error("verdict result with nonzero data byte");

    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("output queue overflow");

    // A pop with no byte taken shrinks the queue by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_pop && !in_accept |=> q_count == $past(q_count) - QCNT_W'(1))
        else $error("output queue count mismatch after pop");

endmodule

[test/tb_packet_receiver_crc_seq_check_unit.sv]
// Self-checking testbench for the framed packet receiver with CRC-32 and sequence check.
module tb_packet_receiver_crc_seq_check_unit;
    import pktrx_pkg::*;

    localparam int PAYLOAD_CAP    = 512;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_TAIL     = 8;
    localparam int RANDOM_BYTES   = 400;
    localparam int HOLD_CYCLES    = 80;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [9:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // Receiver state mirrored from the incoming byte stream.
    logic        rx_in_body;
    logic [2:0]  rx_hdr_pos;
    logic [7:0]  rx_type;
    logic [7:0]  rx_seq;
    logic [15:0] rx_len;
    logic [31:0] rx_crc;
    logic [31:0] body_crc;
    logic [15:0] body_count;
    logic [7:0]  body_first;
    logic [7:0]  next_seq;
    logic [23:0] total_bytes;
    logic [9:0]  len_limit_cfg;

    result_t due_results[$];
    int      mismatches;
    int      bytes_sent;
    int      idle_cycles;
    int      stall_left;
    int      sink_hold_req;
    bit      src_gaps;
    bit      sink_gaps;

    packet_receiver_crc_seq_check_unit #(
        .MAX_PAYLOAD_LIMIT(PAYLOAD_CAP)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [15:0] length_cap();
        return (len_limit_cfg < PAYLOAD_CAP) ? 16'(len_limit_cfg) : 16'(PAYLOAD_CAP);
    endfunction

    function automatic void queue_result(input result_kind_t kind, input logic [7:0] data,
                                         input verdict_t v, input logic [7:0] seq,
                                         input logic last_flag);
        result_t r;
        r.result_kind    = kind;
        r.data_byte      = data;
        r.verdict        = v;
        r.reply_seq      = seq;
        r.packet_type    = rx_type;
        r.payload_len    = rx_len;
        r.accepted_total = total_bytes;
        r.last           = last_flag;
        due_results.push_back(r);
    endfunction

    // Verdict for a packet whose payload arrived intact; updates the counters.
    function automatic void judge_packet(output verdict_t v, output logic [7:0] seq);
        logic [24:0] sum;
        if (rx_type == TYPE_DATA)
        begin
            if (rx_seq != next_seq)
            begin
                v   = VERDICT_NACK_SEQ;
                seq = rx_seq;
            end
            else
            begin
                seq         = next_seq;
                sum         = {1'b0, total_bytes} + {9'd0, rx_len};
                total_bytes = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[23:0];
                next_seq    = next_seq + 8'd1;
                v           = VERDICT_ACK;
            end
        end
        else
        begin
            seq = rx_seq;
            if (rx_type == TYPE_CMD && rx_len == 16'd1 && body_first == CMD_DONE)
            begin
                next_seq    = 8'd0;
                total_bytes = 24'd0;
                v           = VERDICT_DONE;
            end
            else if (rx_type == TYPE_CMD)
                v = VERDICT_IGNORED;
            else
                v = VERDICT_NACK_TYPE;
        end
    endfunction

    // Works out the results that one accepted byte causes.
    function automatic void parse_rx_byte(input logic [7:0] b);
        verdict_t    v;
        logic [7:0]  seq;
        if (!rx_in_body)
        begin
            case (rx_hdr_pos)
                3'd0:    rx_type = b;
                3'd1:    rx_seq = b;
                3'd2:    rx_len[7:0] = b;
                3'd3:    rx_len[15:8] = b;
                default: rx_crc = {b, rx_crc[31:8]};
            endcase
            if (rx_hdr_pos != HDR_LAST_INDEX)
            begin
                rx_hdr_pos = rx_hdr_pos + 3'd1;
                return;
            end
            rx_hdr_pos = 3'd0;
            if (rx_len > length_cap())
                queue_result(KIND_VERDICT, 8'd0, VERDICT_NACK_READ, next_seq, 1'b1);
            else if (rx_len == 16'd0)
            begin
                judge_packet(v, seq);
                queue_result(KIND_VERDICT, 8'd0, v, seq, 1'b1);
            end
            else
            begin
                rx_in_body = 1'b1;
                body_crc   = CRC_INIT;
                body_count = 16'd0;
            end
            return;
        end
        if (body_count == 16'd0)
            body_first = b;
        body_crc   = crc32_step(body_crc, b);
        body_count = body_count + 16'd1;
        queue_result(KIND_DATA, b, VERDICT_ACK, rx_seq, body_count < rx_len);
        if (body_count == rx_len)
        begin
            rx_in_body = 1'b0;
            body_count = 16'd0;
            if (~body_crc != rx_crc)
                queue_result(KIND_VERDICT, 8'd0, VERDICT_NACK_READ, next_seq, 1'b1);
            else
            begin
                judge_packet(v, seq);
                queue_result(KIND_VERDICT, 8'd0, v, seq, 1'b1);
            end
        end
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Must be called right after a rising edge; returns at the edge that took the byte.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_gaps ? draw_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
        parse_rx_byte(b);
    endtask

    task automatic send_packet(input logic [7:0] ptype, input logic [7:0] pseq,
                               input logic [15:0] plen, input bit corrupt_crc,
                               input bit done_cmd);
        logic [7:0]  body[$];
        logic [31:0] crc;
        int          n;
        crc = CRC_INIT;
        n   = (plen > length_cap()) ? 0 : int'(plen);
        for (int i = 0; i < n; i++)
        begin
            body.push_back((i == 0 && done_cmd) ? CMD_DONE : 8'($urandom));
            crc = crc32_step(crc, body[i]);
        end
        crc = ~crc;
        if (corrupt_crc)
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
        send_byte(ptype);
        send_byte(pseq);
        send_byte(plen[7:0]);
        send_byte(plen[15:8]);
        for (int k = 0; k < 4; k++)
            send_byte(crc[8*k +: 8]);
        foreach (body[i])
            send_byte(body[i]);
    endtask

    // Only the last header byte can cause a result, so the block may still be busy after the last one.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic write_len_limit(input logic [9:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we        <= 1'b0;
        len_limit_cfg = value;
    endtask

    task automatic test_data_ack();
        send_packet(TYPE_DATA, next_seq, 16'd1, 1'b0, 1'b0);
        // A zero-length packet is judged without looking at its CRC.
        send_packet(TYPE_DATA, next_seq, 16'd0, 1'b1, 1'b0);
        send_packet(TYPE_DATA, next_seq, 16'd3, 1'b0, 1'b0);
    endtask

    task automatic test_rejections();
        send_packet(TYPE_DATA, next_seq + 8'd1, 16'd2, 1'b0, 1'b0);
        send_packet(TYPE_DATA, next_seq, 16'd2, 1'b1, 1'b0);
        send_packet(8'hFF, 8'hFF, 16'd1, 1'b0, 1'b0);
        send_packet(8'h00, 8'h00, 16'd0, 1'b0, 1'b0);
        send_packet(TYPE_CMD, 8'h5A, 16'd2, 1'b0, 1'b1);
        send_packet(TYPE_CMD, 8'hA5, 16'd1, 1'b0, 1'b0);
        send_packet(TYPE_DATA, next_seq, 16'hFFFF, 1'b0, 1'b0);
    endtask

    task automatic test_done_clears();
        send_packet(TYPE_DATA, next_seq, 16'd2, 1'b0, 1'b0);
        send_packet(TYPE_CMD, 8'h33, 16'd1, 1'b0, 1'b1);
        send_packet(TYPE_DATA, next_seq, 16'd1, 1'b0, 1'b0);
    endtask

    task automatic test_length_limit();
        wait_drained();
        write_len_limit(10'd1);
        send_packet(TYPE_DATA, next_seq, 16'd1, 1'b0, 1'b0);
        send_packet(TYPE_DATA, next_seq, 16'd2, 1'b0, 1'b0);
        // With a zero limit only zero-length packets get through.
        wait_drained();
        write_len_limit(10'd0);
        send_packet(TYPE_DATA, next_seq, 16'd1, 1'b0, 1'b0);
        send_packet(TYPE_DATA, next_seq, 16'd0, 1'b0, 1'b0);
        wait_drained();
        write_len_limit(10'd512);
        send_packet(TYPE_DATA, next_seq, 16'd513, 1'b0, 1'b0);
        wait_drained();
        write_len_limit(10'd33);
        send_packet(TYPE_DATA, next_seq, 16'd34, 1'b0, 1'b0);
        send_packet(TYPE_DATA, next_seq, 16'd33, 1'b0, 1'b0);
        wait_drained();
        write_len_limit(10'd512);
    endtask

    task automatic test_backpressure();
        wait_drained();
        src_gaps      = 1'b0;
        sink_hold_req = HOLD_CYCLES;
        send_packet(TYPE_DATA, next_seq, 16'd40, 1'b0, 1'b0);
        wait_drained();
        src_gaps = 1'b1;
    endtask

    task automatic send_random_packet();
        logic [15:0] cap;
        logic [15:0] len;
        int          r;
        int          noise;
        cap = length_cap();
        r   = $urandom_range(0, 6);
        if (r < 4)
            len = 16'($urandom_range(0, (cap < 12) ? cap : 12));
        else if (r < 5)
            len = (cap <= 64) ? cap : 16'($urandom_range(13, 64));
        else
            len = 16'($urandom_range(0, (cap < 64) ? cap : 64));
        r = $urandom_range(0, 99);
        if (r < 50)
            send_packet(TYPE_DATA, next_seq, len, 1'b0, 1'b0);
        else if (r < 58)
            send_packet(TYPE_DATA, next_seq + 8'($urandom_range(1, 255)), len, 1'b0, 1'b0);
        else if (r < 64)
            send_packet(TYPE_DATA, next_seq, len, 1'b1, 1'b0);
        else if (r < 70)
            send_packet(TYPE_CMD, 8'($urandom), 16'd1, 1'b0, 1'b1);
        else if (r < 76)
            send_packet(TYPE_CMD, 8'($urandom), len, 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
        else if (r < 84)
            send_packet(8'($urandom), 8'($urandom), len, 1'b0, 1'b0);
        else if (r < 90)
            send_packet(TYPE_DATA, next_seq, 16'($urandom_range(cap + 1, 16'hFFFF)), 1'b0, 1'b0);
        else
        begin
            // Raw bytes, then filler until the parser is back at a header boundary.
            noise = $urandom_range(1, 12);
            repeat (noise)
                send_byte(8'($urandom));
            while (rx_in_body || rx_hdr_pos != 3'd0)
                send_byte(8'($urandom));
        end
    endtask

    task automatic test_random_traffic();
        int goal;
        int phase_end;
        int pick;
        goal = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < goal)
        begin
            wait_drained();
            pick = $urandom_range(0, 4);
            case (pick)
                0:       write_len_limit(10'd1);
                1:       write_len_limit(10'd512);
                2:       write_len_limit(10'($urandom_range(2, 64)));
                default: write_len_limit(10'($urandom_range(1, 512)));
            endcase
            src_gaps  = ($urandom_range(0, 3) != 0);
            sink_gaps = ($urandom_range(0, 3) != 0);
            phase_end = bytes_sent + 60;
            while (bytes_sent < phase_end)
                send_random_packet();
        end
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (sink_hold_req != 0)
        begin
            stall_left    = sink_hold_req;
            sink_hold_req = 0;
        end
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (sink_gaps && $urandom_range(0, 3) == 0)
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                         : $urandom_range(8, 30);
        end
    end

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (due_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with nothing expected, expected none, got tdata %0h",
                         $time, m_axis_tdata);
            end
            else
            begin
                want = due_results.pop_front();
                compare_field("result_kind", 32'(want.result_kind), 32'(m_axis_tuser));
                compare_field("data_byte", 32'(want.data_byte), 32'(m_axis_tdata[7:0]));
                compare_field("verdict", 32'(want.verdict), 32'(m_axis_tdata[10:8]));
                compare_field("reply_seq", 32'(want.reply_seq), 32'(m_axis_tdata[18:11]));
                compare_field("packet_type", 32'(want.packet_type), 32'(m_axis_tdata[26:19]));
                compare_field("payload_len", 32'(want.payload_len), 32'(m_axis_tdata[42:27]));
                compare_field("accepted_total", 32'(want.accepted_total),
                              32'(m_axis_tdata[66:43]));
                compare_field("last", 32'(want.last), 32'(m_axis_tlast));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 10'd0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = 8'd0;
        m_axis_tready   = 1'b0;
        mismatches      = 0;
        bytes_sent      = 0;
        idle_cycles     = 0;
        stall_left      = 0;
        sink_hold_req   = 0;
        src_gaps        = 1'b1;
        sink_gaps       = 1'b1;
        rx_in_body      = 1'b0;
        rx_hdr_pos      = 3'd0;
        rx_type         = 8'd0;
        rx_seq          = 8'd0;
        rx_len          = 16'd0;
        rx_crc          = 32'd0;
        body_crc        = CRC_INIT;
        body_count      = 16'd0;
        body_first      = 8'd0;
        next_seq        = 8'd0;
        total_bytes     = 24'd0;
        len_limit_cfg   = MAX_PAYLOAD_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_data_ack();
        test_rejections();
        test_done_clears();
        test_length_limit();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        if (mismatches == 0 && due_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
